// ===== sv/bpfm_pkg.sv =====
// Package: shared types and constants for the buffer pool frame manager.
`default_nettype none
package bpfm_pkg;
  localparam int PoolFrames = 16;
  localparam int FrameW = $clog2(PoolFrames);
  localparam int CountW = $clog2(PoolFrames + 1);
  localparam int PinMax = 255;
  localparam int PinW = 8;
  localparam int PageW = 31;

  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_FETCH = 3'd0;
  localparam cmd_t CMD_UNPIN = 3'd1;
  localparam cmd_t CMD_FLUSH = 3'd2;
  localparam cmd_t CMD_NEW = 3'd3;
  localparam cmd_t CMD_DELETE = 3'd4;
  localparam cmd_t CMD_FLUSH_ALL = 3'd5;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_REPLY = 2'd0;
  localparam kind_t KIND_WRITE = 2'd1;
  localparam kind_t KIND_READ = 2'd2;
  localparam kind_t KIND_DEALLOC = 2'd3;

  // operations the controller asks of the datapath
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,       // capture transaction, lookup
    OP_PIN,        // fetch hit: pin+1, leave LRU
    OP_VICTIM,     // take victim frame
    OP_CLAIM,      // set tag, pin 1, clean, leave LRU
    OP_UNPIN,
    OP_CLEAN,      // clear dirty of hit frame
    OP_DELETE,
    OP_SCAN_CLEAN, // clear dirty of scan frame, advance scan
    OP_SCAN_SKIP,
    OP_LRU_STEP    // one compaction step of LRU list
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic hit;
    logic pin_zero;
    logic pin_max;
    logic got;
    logic victim_dirty;
    logic scan_valid;
    logic scan_done;
    logic lru_busy;
  } dp_stat_t;
endpackage
`default_nettype wire

// ===== sv/bpfm_datapath.sv =====
// Datapath: frame tables, free FIFO, LRU list and lookup.
`default_nettype none
module bpfm_datapath (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire bpfm_pkg::dp_cmd_t ctl,
  input  wire bpfm_pkg::cmd_t in_cmd,
  input  wire logic [bpfm_pkg::PageW-1:0] in_page_id,
  input  wire logic in_mark_dirty,
  input  wire logic [bpfm_pkg::PageW-1:0] in_alloc_page_id,
  output bpfm_pkg::dp_stat_t stat,
  output logic [bpfm_pkg::PageW-1:0] page_r,
  output logic [bpfm_pkg::PageW-1:0] alloc_r,
  output logic [bpfm_pkg::FrameW-1:0] frame_r,
  output logic [bpfm_pkg::PageW-1:0] victim_tag,
  output logic [bpfm_pkg::FrameW-1:0] scan_r,
  output logic [bpfm_pkg::PageW-1:0] scan_tag
);
  import bpfm_pkg::*;

  logic [PageW-1:0] tag_r [PoolFrames];
  logic [PoolFrames-1:0] valid_r, dirty_r;
  logic [PinW-1:0] pin_r [PoolFrames];
  logic [FrameW-1:0] free_r [PoolFrames];
  logic [CountW-1:0] free_cnt_r;
  logic [FrameW-1:0] lru_r [PoolFrames];
  logic [CountW-1:0] lru_cnt_r;
  cmd_t cmd_r;
  logic md_r, hit_r, got_r;
  // LRU removal walk
  logic lru_busy_r;
  logic [CountW-1:0] rd_r, wr_r;
  logic [FrameW-1:0] rm_r;
  logic [CountW-1:0] scan_cnt_r;

  logic lhit;
  logic [FrameW-1:0] lfr;
  logic [PageW-1:0] key;
  logic in_lru;

  assign key = (ctl.op == OP_LOAD) ? in_page_id : page_r;

  always_comb begin
    lhit = 1'b0;
    lfr = '0;
    for (int i = PoolFrames - 1; i >= 0; i--) begin
      if (valid_r[i] && tag_r[i] == key) begin
        lhit = 1'b1;
        lfr = FrameW'(i);
      end
    end
  end

  always_comb begin
    in_lru = 1'b0;
    for (int i = 0; i < PoolFrames; i++) begin
      if (CountW'(i) < lru_cnt_r && lru_r[i] == frame_r) in_lru = 1'b1;
    end
  end

  assign victim_tag = tag_r[frame_r];
  assign scan_tag = tag_r[scan_r];

  always_comb begin
    stat.cmd = cmd_r;
    stat.hit = hit_r;
    stat.pin_zero = (pin_r[frame_r] == '0);
    stat.pin_max = (32'(pin_r[frame_r]) >= PinMax);
    stat.got = got_r;
    stat.victim_dirty = valid_r[frame_r] && dirty_r[frame_r];
    stat.scan_valid = valid_r[scan_r];
    stat.scan_done = (scan_cnt_r == CountW'(PoolFrames - 1));
    stat.lru_busy = lru_busy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
      for (int i = 0; i < PoolFrames; i++) begin
        pin_r[i] <= '0;
        free_r[i] <= FrameW'(i);
      end
      free_cnt_r <= CountW'(PoolFrames);
      lru_cnt_r <= '0;
      lru_busy_r <= 1'b0;
      hit_r <= 1'b0;
      got_r <= 1'b0;
      cmd_r <= CMD_FETCH;
      scan_r <= '0;
      scan_cnt_r <= '0;
    end else begin
      case (ctl.op)
        OP_LOAD: begin
          cmd_r <= in_cmd;
          page_r <= in_page_id;
          alloc_r <= in_alloc_page_id;
          md_r <= in_mark_dirty;
          hit_r <= lhit;
          frame_r <= lhit ? lfr : '0;
          scan_r <= '0;
          scan_cnt_r <= '0;
        end
        OP_PIN: begin
          pin_r[frame_r] <= pin_r[frame_r] + 1'b1;
          lru_busy_r <= 1'b1;
          rm_r <= frame_r;
          rd_r <= '0;
          wr_r <= '0;
        end
        OP_VICTIM: begin
          got_r <= 1'b0;
          if (free_cnt_r != '0) begin
            got_r <= 1'b1;
            frame_r <= free_r[0];
            for (int i = 0; i < PoolFrames - 1; i++) free_r[i] <= free_r[i + 1];
            free_cnt_r <= free_cnt_r - 1'b1;
          end else if (lru_cnt_r != '0) begin
            got_r <= 1'b1;
            frame_r <= lru_r[0];
            for (int i = 0; i < PoolFrames - 1; i++) lru_r[i] <= lru_r[i + 1];
            lru_cnt_r <= lru_cnt_r - 1'b1;
          end
        end
        OP_CLAIM: begin
          tag_r[frame_r] <= (cmd_r == CMD_NEW) ? alloc_r : page_r;
          valid_r[frame_r] <= 1'b1;
          pin_r[frame_r] <= PinW'(1);
          dirty_r[frame_r] <= 1'b0;
          lru_busy_r <= 1'b1;
          rm_r <= frame_r;
          rd_r <= '0;
          wr_r <= '0;
        end
        OP_UNPIN: begin
          pin_r[frame_r] <= pin_r[frame_r] - 1'b1;
          dirty_r[frame_r] <= dirty_r[frame_r] | md_r;
          if (pin_r[frame_r] == PinW'(1) && !in_lru &&
              lru_cnt_r < CountW'(PoolFrames)) begin
            lru_r[lru_cnt_r[FrameW-1:0]] <= frame_r;
            lru_cnt_r <= lru_cnt_r + 1'b1;
          end
        end
        OP_CLEAN: dirty_r[frame_r] <= 1'b0;
        OP_DELETE: begin
          valid_r[frame_r] <= 1'b0;
          dirty_r[frame_r] <= 1'b0;
          pin_r[frame_r] <= '0;
          if (free_cnt_r < CountW'(PoolFrames)) begin
            free_r[free_cnt_r[FrameW-1:0]] <= frame_r;
            free_cnt_r <= free_cnt_r + 1'b1;
          end
          lru_busy_r <= 1'b1;
          rm_r <= frame_r;
          rd_r <= '0;
          wr_r <= '0;
        end
        OP_SCAN_CLEAN, OP_SCAN_SKIP: begin
          if (ctl.op == OP_SCAN_CLEAN) dirty_r[scan_r] <= 1'b0;
          scan_r <= scan_r + 1'b1;
          scan_cnt_r <= scan_cnt_r + 1'b1;
        end
        OP_LRU_STEP: begin
          if (rd_r >= lru_cnt_r) begin
            lru_cnt_r <= wr_r;
            lru_busy_r <= 1'b0;
          end else begin
            if (lru_r[rd_r[FrameW-1:0]] != rm_r) begin
              lru_r[wr_r[FrameW-1:0]] <= lru_r[rd_r[FrameW-1:0]];
              wr_r <= wr_r + 1'b1;
            end
            rd_r <= rd_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/bpfm_ctrl.sv =====
// Controller: command sequencing and result transaction generation.
`default_nettype none
module bpfm_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [1:0] out_out_kind,
  output logic [bpfm_pkg::PageW-1:0] out_page_out,
  output logic [bpfm_pkg::FrameW-1:0] out_frame_out,
  output logic out_ok,
  output logic out_last,
  output bpfm_pkg::dp_cmd_t ctl,
  input  wire bpfm_pkg::dp_stat_t stat,
  input  wire logic [bpfm_pkg::PageW-1:0] page_r,
  input  wire logic [bpfm_pkg::PageW-1:0] alloc_r,
  input  wire logic [bpfm_pkg::FrameW-1:0] frame_r,
  input  wire logic [bpfm_pkg::PageW-1:0] victim_tag,
  input  wire logic [bpfm_pkg::FrameW-1:0] scan_r,
  input  wire logic [bpfm_pkg::PageW-1:0] scan_tag
);
  import bpfm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_CLAIM, S_READ, S_SCAN, S_REPLY, S_LRU}
    state_t;
  state_t state_r, state_nxt;
  logic ov_nxt, free;
  kind_t k_nxt;
  logic [PageW-1:0] p_nxt;
  logic [FrameW-1:0] f_nxt;
  logic ok_nxt, last_nxt;
  // pending reply after emitting a request
  logic rok_r, rok_nxt;
  logic [PageW-1:0] rp_r, rp_nxt;
  logic [FrameW-1:0] rf_r, rf_nxt;

  assign free = !out_valid || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl.op = OP_NONE;
    ov_nxt = out_valid && out_stall;
    k_nxt = kind_t'(out_out_kind);
    p_nxt = out_page_out;
    f_nxt = out_frame_out;
    ok_nxt = out_ok;
    last_nxt = out_last;
    rok_nxt = rok_r;
    rp_nxt = rp_r;
    rf_nxt = rf_r;
    case (state_r)
      S_IDLE: if (in_valid) begin
        ctl.op = OP_LOAD;
        state_nxt = S_DECODE;
      end
      S_DECODE: if (free) begin
        state_nxt = S_REPLY;
        rp_nxt = page_r;
        rf_nxt = stat.hit ? frame_r : '0;
        rok_nxt = 1'b0;
        case (stat.cmd)
          CMD_FETCH: if (stat.hit) begin
            if (!stat.pin_max) begin
              ctl.op = OP_PIN;
              rok_nxt = 1'b1;
            end
          end else begin
            ctl.op = OP_VICTIM;
            state_nxt = S_CLAIM;
          end
          CMD_UNPIN: if (stat.hit && !stat.pin_zero) begin
            ctl.op = OP_UNPIN;
            rok_nxt = 1'b1;
          end else rf_nxt = '0;
          CMD_FLUSH: if (stat.hit) begin
            ctl.op = OP_CLEAN;
            rok_nxt = 1'b1;
            ov_nxt = 1'b1;
            {k_nxt, p_nxt, f_nxt, ok_nxt, last_nxt} = {KIND_WRITE, page_r, frame_r, 2'b00};
          end
          CMD_NEW: begin
            ctl.op = OP_VICTIM;
            state_nxt = S_CLAIM;
          end
          CMD_DELETE: begin
            ov_nxt = 1'b1;
            {k_nxt, p_nxt, f_nxt, ok_nxt, last_nxt} =
              {KIND_DEALLOC, page_r, FrameW'(0), 2'b00};
            rok_nxt = !stat.hit || stat.pin_zero;
            if (stat.hit && stat.pin_zero) ctl.op = OP_DELETE;
          end
          CMD_FLUSH_ALL: begin
            state_nxt = S_SCAN;
            rp_nxt = '0;
            rf_nxt = '0;
            rok_nxt = 1'b1;
          end
          default: begin
            rp_nxt = '0;
            rf_nxt = '0;
          end
        endcase
      end
      S_CLAIM: begin
        if (!stat.got) begin
          rp_nxt = (stat.cmd == CMD_NEW) ? '0 : page_r;
          rf_nxt = '0;
          rok_nxt = 1'b0;
          state_nxt = S_REPLY;
        end else if (free) begin
          ctl.op = OP_CLAIM;
          rok_nxt = 1'b1;
          rf_nxt = frame_r;
          rp_nxt = (stat.cmd == CMD_NEW) ? alloc_r : page_r;
          state_nxt = (stat.cmd == CMD_NEW) ? S_REPLY : S_READ;
          if (stat.victim_dirty) begin
            ov_nxt = 1'b1;
            {k_nxt, p_nxt, f_nxt, ok_nxt, last_nxt} = {KIND_WRITE, victim_tag, frame_r, 2'b00};
          end
        end
      end
      S_READ: if (free) begin
        ov_nxt = 1'b1;
        {k_nxt, p_nxt, f_nxt, ok_nxt, last_nxt} = {KIND_READ, page_r, frame_r, 2'b00};
        state_nxt = S_REPLY;
      end
      S_SCAN: if (free) begin
        if (stat.scan_valid) begin
          ctl.op = OP_SCAN_CLEAN;
          ov_nxt = 1'b1;
          {k_nxt, p_nxt, f_nxt, ok_nxt, last_nxt} = {KIND_WRITE, scan_tag, scan_r, 2'b00};
        end else ctl.op = OP_SCAN_SKIP;
        if (stat.scan_done) state_nxt = S_REPLY;
      end
      S_REPLY: if (free) begin
        ov_nxt = 1'b1;
        {k_nxt, p_nxt, f_nxt, ok_nxt, last_nxt} = {KIND_REPLY, rp_r, rf_r, rok_r, 1'b1};
        state_nxt = stat.lru_busy ? S_LRU : S_IDLE;
      end
      S_LRU: begin
        ctl.op = OP_LRU_STEP;
        if (!stat.lru_busy) begin
          ctl.op = OP_NONE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= ov_nxt;
    end
    out_out_kind <= k_nxt;
    out_page_out <= p_nxt;
    out_frame_out <= f_nxt;
    out_ok <= ok_nxt;
    out_last <= last_nxt;
    rok_r <= rok_nxt;
    rp_r <= rp_nxt;
    rf_r <= rf_nxt;
  end
endmodule
`default_nettype wire

// ===== sv/buffer_pool_frame_manager.sv =====
// Top level: buffer pool frame manager with LRU replacement.
// One command at a time: the next command is accepted only once its results are
// issued; flush all walks every frame. A command that takes a frame off the LRU
// list then walks the list after the reply. Output stalls hold the sequence back.
// Synchronous active-low reset: all frames free in order, LRU empty, no pages.
`default_nettype none
module buffer_pool_frame_manager (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [2:0] in_cmd,
  input  wire logic [30:0] in_page_id,
  input  wire logic in_mark_dirty,
  input  wire logic [30:0] in_alloc_page_id,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [1:0] out_out_kind,
  output logic [30:0] out_page_out,
  output logic [3:0] out_frame_out,
  output logic out_ok,
  output logic out_last
);
  import bpfm_pkg::*;

  dp_cmd_t ctl;
  dp_stat_t stat;
  logic [PageW-1:0] page_r, alloc_r, victim_tag, scan_tag;
  logic [FrameW-1:0] frame_r, scan_r;

  bpfm_datapath u_dp (
    .clk, .rst_n, .ctl, .in_cmd(cmd_t'(in_cmd)), .in_page_id, .in_mark_dirty,
    .in_alloc_page_id, .stat, .page_r, .alloc_r, .frame_r, .victim_tag, .scan_r, .scan_tag
  );

  bpfm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_out_kind,
    .out_page_out, .out_frame_out, .out_ok, .out_last, .ctl, .stat, .page_r, .alloc_r,
    .frame_r, .victim_tag, .scan_r, .scan_tag
  );
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench: directed table and random command stream for the buffer pool frame manager.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bpfm_pkg::*;

  localparam cmd_t CMD_UNUSED_A = 3'd6;
  localparam cmd_t CMD_UNUSED_B = 3'd7;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [2:0] in_cmd;
  logic [30:0] in_page_id, in_alloc_page_id;
  logic in_mark_dirty;
  logic out_valid, out_stall;
  logic [1:0] out_out_kind;
  logic [30:0] out_page_out;
  logic [3:0] out_frame_out;
  logic out_ok, out_last;

  buffer_pool_frame_manager DUT (.*);

  typedef struct packed {
    kind_t kind;
    logic [30:0] page;
    logic [3:0] frame;
    logic ok;
    logic last;
  } disk_req_t;

  typedef struct {
    cmd_t cmd;
    logic [30:0] page;
    logic mdirty;
    logic [30:0] alloc;
    bit checked;
    disk_req_t reply;
  } stim_row_t;

  // shadow pool state
  logic [30:0] tag_q[PoolFrames];
  bit valid_q[PoolFrames];
  int pins_q[PoolFrames];
  bit dirty_q[PoolFrames];
  int free_q[$];
  int lru_q[$];

  disk_req_t pending_q[$];
  int errors = 0, cycles = 0, accepted = 0, replies = 0, writes = 0;
  bit hold_off = 0;
  stim_row_t dir_tab[$];
  stim_row_t row;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (accepted >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic void pool_reset();
    free_q = {};
    lru_q = {};
    for (int i = 0; i < PoolFrames; i++) begin
      valid_q[i] = 0; pins_q[i] = 0; dirty_q[i] = 0; tag_q[i] = '0;
      free_q.push_back(i);
    end
  endfunction

  function automatic int find_frame(logic [30:0] p);
    for (int i = 0; i < PoolFrames; i++)
      if (valid_q[i] && tag_q[i] == p) return i;
    return -1;
  endfunction

  function automatic void lru_drop(int f);
    for (int i = lru_q.size() - 1; i >= 0; i--)
      if (lru_q[i] == f) lru_q.delete(i);
  endfunction

  function automatic void push_req(kind_t k, logic [30:0] p, int f, logic ok, logic lst);
    disk_req_t r;
    r.kind = k; r.page = p; r.frame = f[3:0]; r.ok = ok; r.last = lst;
    pending_q.push_back(r);
  endfunction

  // victim from free list, else LRU front; -1 if none
  function automatic int claim(logic [30:0] p);
    int f;
    if (free_q.size() > 0) begin
      f = free_q[0];
      free_q.delete(0);
    end else if (lru_q.size() > 0) begin
      f = lru_q[0];
      lru_q.delete(0);
    end else return -1;
    if (valid_q[f] && dirty_q[f]) push_req(KIND_WRITE, tag_q[f], f, 1'b0, 1'b0);
    tag_q[f] = p; valid_q[f] = 1; pins_q[f] = 1; dirty_q[f] = 0;
    lru_drop(f);
    return f;
  endfunction

  function automatic void predict_pool(cmd_t c, logic [30:0] p, logic md, logic [30:0] a);
    int f;
    case (c)
      CMD_FETCH: begin
        f = find_frame(p);
        if (f >= 0) begin
          if (pins_q[f] >= PinMax) push_req(KIND_REPLY, p, f, 1'b0, 1'b1);
          else begin
            pins_q[f]++; lru_drop(f);
            push_req(KIND_REPLY, p, f, 1'b1, 1'b1);
          end
        end else begin
          f = claim(p);
          if (f < 0) push_req(KIND_REPLY, p, 0, 1'b0, 1'b1);
          else begin
            push_req(KIND_READ, p, f, 1'b0, 1'b0);
            push_req(KIND_REPLY, p, f, 1'b1, 1'b1);
          end
        end
      end
      CMD_UNPIN: begin
        f = find_frame(p);
        if (f < 0 || pins_q[f] == 0) push_req(KIND_REPLY, p, 0, 1'b0, 1'b1);
        else begin
          pins_q[f]--;
          if (pins_q[f] == 0 && !(f inside {lru_q})) lru_q.push_back(f);
          dirty_q[f] |= md;
          push_req(KIND_REPLY, p, f, 1'b1, 1'b1);
        end
      end
      CMD_FLUSH: begin
        f = find_frame(p);
        if (f < 0) push_req(KIND_REPLY, p, 0, 1'b0, 1'b1);
        else begin
          push_req(KIND_WRITE, p, f, 1'b0, 1'b0);
          dirty_q[f] = 0;
          push_req(KIND_REPLY, p, f, 1'b1, 1'b1);
        end
      end
      CMD_NEW: begin
        f = claim(a);
        if (f < 0) push_req(KIND_REPLY, 31'd0, 0, 1'b0, 1'b1);
        else push_req(KIND_REPLY, a, f, 1'b1, 1'b1);
      end
      CMD_DELETE: begin
        push_req(KIND_DEALLOC, p, 0, 1'b0, 1'b0);
        f = find_frame(p);
        if (f < 0) push_req(KIND_REPLY, p, 0, 1'b1, 1'b1);
        else if (pins_q[f] > 0) push_req(KIND_REPLY, p, f, 1'b0, 1'b1);
        else begin
          valid_q[f] = 0; tag_q[f] = '0; pins_q[f] = 0; dirty_q[f] = 0;
          lru_drop(f);
          if (free_q.size() < PoolFrames) free_q.push_back(f);
          push_req(KIND_REPLY, p, f, 1'b1, 1'b1);
        end
      end
      CMD_FLUSH_ALL: begin
        for (int i = 0; i < PoolFrames; i++)
          if (valid_q[i]) begin
            push_req(KIND_WRITE, tag_q[i], i, 1'b0, 1'b0);
            dirty_q[i] = 0;
          end
        push_req(KIND_REPLY, 31'd0, 0, 1'b1, 1'b1);
      end
      default: push_req(KIND_REPLY, 31'd0, 0, 1'b0, 1'b1);
    endcase
  endfunction

  // receiver: stall pattern plus optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else case (cycles % 64 / 16)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (cycles % 5 == 0);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    disk_req_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result kind=%0d page=%0h", out_out_kind, out_page_out);
        errors++;
      end else begin
        e = pending_q[0];
        pending_q.delete(0);
        if (out_out_kind !== e.kind) begin
          $error("out_kind exp %0d got %0d", e.kind, out_out_kind); errors++;
        end
        if (out_page_out !== e.page) begin
          $error("page_out exp %0h got %0h", e.page, out_page_out); errors++;
        end
        if (out_frame_out !== e.frame) begin
          $error("frame_out exp %0d got %0d", e.frame, out_frame_out); errors++;
        end
        if (out_ok !== e.ok) begin
          $error("ok exp %0b got %0b", e.ok, out_ok); errors++;
        end
        if (out_last !== e.last) begin
          $error("last exp %0b got %0b", e.last, out_last); errors++;
        end
        if (e.kind == KIND_REPLY) replies++;
        if (e.kind == KIND_WRITE) writes++;
      end
    end
  end

  task automatic send_cmd(cmd_t c, logic [30:0] p, logic md, logic [30:0] a);
    in_valid <= 1'b1; in_cmd <= c; in_page_id <= p;
    in_mark_dirty <= md; in_alloc_page_id <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pool(c, p, md, a);
    accepted++;
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 9) < 3) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic void add_row(cmd_t c, logic [30:0] p, logic md, logic [30:0] a,
                                  bit chk = 1'b0, kind_t k = KIND_REPLY,
                                  logic [30:0] rp = '0, int rf = 0, logic rok = 1'b0);
    stim_row_t r;
    r.cmd = c; r.page = p; r.mdirty = md; r.alloc = a; r.checked = chk;
    r.reply.kind = k; r.reply.page = rp; r.reply.frame = rf[3:0];
    r.reply.ok = rok; r.reply.last = 1'b1;
    dir_tab.push_back(r);
  endfunction

  function automatic logic [30:0] pick_page();
    case ($urandom_range(0, 9))
      0: return 31'($urandom);
      1: return 31'h7fffffff - 31'($urandom_range(0, 3));
      default: return 31'($urandom_range(0, 23));
    endcase
  endfunction

  initial begin
    cmd_t c;
    int n_rand;
    rst_n = 0; in_valid = 0; in_cmd = CMD_FETCH; in_page_id = '0;
    in_mark_dirty = 0; in_alloc_page_id = '0; out_stall = 0;
    pool_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: replies after reset typed in, the rest predicted
    add_row(CMD_UNPIN, 31'd7, 1'b1, 31'd0, 1'b1, KIND_REPLY, 31'd7, 0, 1'b0);
    add_row(CMD_FLUSH, 31'h7fffffff, 1'b0, 31'd0, 1'b1, KIND_REPLY, 31'h7fffffff, 0, 1'b0);
    add_row(CMD_FLUSH_ALL, 31'd0, 1'b0, 31'd0, 1'b1, KIND_REPLY, 31'd0, 0, 1'b1);
    add_row(CMD_UNUSED_A, 31'h7fffffff, 1'b1, 31'h7fffffff, 1'b1, KIND_REPLY, 31'd0, 0,
            1'b0);
    add_row(CMD_UNUSED_B, 31'd0, 1'b0, 31'd0, 1'b1, KIND_REPLY, 31'd0, 0, 1'b0);
    add_row(CMD_FETCH, 31'h7fffffff, 1'b0, 31'd0);
    add_row(CMD_FETCH, 31'd0, 1'b0, 31'd0);
    add_row(CMD_NEW, 31'd0, 1'b0, 31'h7fffffff);
    add_row(CMD_NEW, 31'd0, 1'b0, 31'd0);
    add_row(CMD_UNPIN, 31'h7fffffff, 1'b1, 31'd0);
    add_row(CMD_UNPIN, 31'h7fffffff, 1'b0, 31'd0);
    add_row(CMD_UNPIN, 31'd0, 1'b1, 31'd0);
    add_row(CMD_FLUSH, 31'd0, 1'b0, 31'd0);
    add_row(CMD_DELETE, 31'd0, 1'b0, 31'd0);
    add_row(CMD_DELETE, 31'h7fffffff, 1'b0, 31'd0);
    add_row(CMD_DELETE, 31'h7fffffff, 1'b0, 31'd0);
    add_row(CMD_DELETE, 31'd12345, 1'b0, 31'd0);
    add_row(CMD_FLUSH_ALL, 31'd0, 1'b0, 31'd0);
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      send_cmd(row.cmd, row.page, row.mdirty, row.alloc);
      if (row.checked) begin
        void'(pending_q.pop_back());
        pending_q.push_back(row.reply);
      end
      maybe_gap();
    end

    // pin one page to the maximum and past it; it stays pinned
    for (int i = 0; i < PinMax + 1; i++) send_cmd(CMD_FETCH, 31'd5, 1'b0, 31'd0);
    send_cmd(CMD_DELETE, 31'd5, 1'b0, 31'd0);

    // fill the pool with pinned pages: no victim left
    for (int i = 0; i < PoolFrames + 2; i++) send_cmd(CMD_NEW, 31'd0, 1'b0, 31'(100 + i));
    send_cmd(CMD_FETCH, 31'd999, 1'b0, 31'd0);
    // duplicate tag
    send_cmd(CMD_UNPIN, 31'd100, 1'b1, 31'd0);
    send_cmd(CMD_NEW, 31'd0, 1'b0, 31'd101);
    for (int i = 0; i < PoolFrames + 2; i++) send_cmd(CMD_UNPIN, 31'(100 + i), i[0], 31'd0);

    // random: mostly well-formed use on a small page set, with noise
    n_rand = 0;
    while (n_rand < 200) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: c = CMD_FETCH;
        6, 7, 8, 9, 10, 11: c = CMD_UNPIN;
        12, 13: c = CMD_FLUSH;
        14, 15: c = CMD_NEW;
        16, 17: c = CMD_DELETE;
        18: c = CMD_FLUSH_ALL;
        default: c = cmd_t'($urandom_range(0, 7));
      endcase
      send_cmd(c, pick_page(), 1'($urandom_range(0, 1)), pick_page());
      n_rand++;
      if (n_rand % ($urandom_range(3, 20)) == 0) maybe_gap();
    end
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("%0d commands accepted, %0d replies and %0d disk writes checked",
             accepted, replies, writes);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
